### sv/slbq_pkg.sv
package slbq_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 11;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic start;      // capture key and action, open the search window
        logic rd_mid;     // read the probe entry
        logic cmp;        // narrow the search window
        logic rd_shift;   // read the entry below the move index
        logic wr_shift;   // move that entry up by one
        logic wr_insert;  // write the key at the insert point
        logic res;        // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic lo_lt_hi;
        logic idx_gt_lo;
        logic full;
    } t_sts;

endpackage

### sv/slbq_ctrl.sv
module slbq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  slbq_pkg::t_sts    i_sts,
    output slbq_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_load;
    logic   r_out_valid;
    logic   accept;
    logic   finish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign finish      = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd           = '0;
        o_cmd.start     = accept;
        o_cmd.res       = finish;
        case (r_state)
            S_SRCH_RD:  o_cmd.rd_mid = i_sts.lo_lt_hi;
            S_SRCH_CMP: o_cmd.cmp    = 1'b1;
            S_SHIFT_RD: begin
                o_cmd.rd_shift  = i_sts.idx_gt_lo;
                o_cmd.wr_insert = !i_sts.idx_gt_lo;
            end
            S_SHIFT_WR: o_cmd.wr_shift = 1'b1;
            default:    ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_load <= (i_action == slbq_pkg::ACT_LOAD);
                        if ((i_action == slbq_pkg::ACT_LOAD && !i_sts.full) ||
                            i_action == slbq_pkg::ACT_QUERY) begin
                            r_state <= S_SRCH_RD;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_SRCH_RD: begin
                    if (i_sts.lo_lt_hi) begin
                        r_state <= S_SRCH_CMP;
                    end else if (r_load) begin
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_SRCH_CMP: r_state <= S_SRCH_RD;
                S_SHIFT_RD: begin
                    r_state <= i_sts.idx_gt_lo ? S_SHIFT_WR : S_FINISH;
                end
                S_SHIFT_WR: r_state <= S_SHIFT_RD;
                S_FINISH: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### sv/slbq_dp.sv
module slbq_dp #(
    parameter int DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  slbq_pkg::t_cmd                    i_cmd,
    output slbq_pkg::t_sts                    o_sts,
    input  logic [1:0]                        i_action,
    input  logic signed [slbq_pkg::DATA_W-1:0] i_value,
    output logic [1:0]                        o_status,
    output logic signed [slbq_pkg::DATA_W-1:0] o_found_value,
    output logic [slbq_pkg::POS_W-1:0]        o_position
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = slbq_pkg::DATA_W;
    localparam int PW = slbq_pkg::POS_W;

    logic signed [DW-1:0] mem [DEPTH];

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [CW-1:0]        r_mid;
    logic [CW-1:0]        r_idx;
    logic [1:0]           r_act;
    logic                 r_drop;
    logic signed [DW-1:0] r_key;
    logic signed [DW-1:0] r_rdata;
    logic signed [DW-1:0] r_best;
    logic [1:0]           r_status;
    logic signed [DW-1:0] r_fv;
    logic [PW-1:0]        r_pos;

    logic [CW-1:0]        n_mid;
    logic [CW-1:0]        idx_dn;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] wr_data;
    logic                 wr_en;
    logic                 go_right;

    assign n_mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_dn = r_idx - CW'(1);

    assign o_sts.lo_lt_hi  = (r_lo < r_hi);
    assign o_sts.idx_gt_lo = (r_idx > r_lo);
    assign o_sts.full      = (r_count == CW'(DEPTH));

    // loads go after equal values, queries stop at the first equal one
    assign go_right = (r_act == slbq_pkg::ACT_LOAD) ? (r_rdata > r_key) : (r_rdata >= r_key);

    assign rd_addr = i_cmd.rd_shift ? idx_dn[AW-1:0] : n_mid[AW-1:0];
    assign wr_en   = i_cmd.wr_shift || i_cmd.wr_insert;
    assign wr_addr = i_cmd.wr_shift ? r_idx[AW-1:0] : r_lo[AW-1:0];
    assign wr_data = i_cmd.wr_shift ? r_rdata : r_key;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_mid || i_cmd.rd_shift) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.start && i_action == slbq_pkg::ACT_CLEAR) begin
            r_count <= '0;
        end else if (i_cmd.wr_insert) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_lo   <= '0;
            r_hi   <= r_count;
            r_idx  <= r_count;
            r_key  <= i_value;
            r_act  <= i_action;
            r_drop <= (i_action == slbq_pkg::ACT_LOAD) && (r_count == CW'(DEPTH));
        end
        if (i_cmd.rd_mid) begin
            r_mid <= n_mid;
        end
        if (i_cmd.cmp) begin
            if (go_right) begin
                r_hi   <= r_mid;
                r_best <= r_rdata;
            end else begin
                r_lo <= r_mid + CW'(1);
            end
        end
        if (i_cmd.wr_shift) begin
            r_idx <= idx_dn;
        end
        if (i_cmd.res) begin
            r_status <= slbq_pkg::ST_OK;
            r_fv     <= '0;
            r_pos    <= '0;
            case (r_act)
                slbq_pkg::ACT_LOAD: begin
                    if (r_drop) begin
                        r_status <= slbq_pkg::ST_FULL;
                        r_pos    <= PW'(r_count);
                    end else begin
                        r_fv  <= r_key;
                        r_pos <= PW'(r_lo);
                    end
                end
                slbq_pkg::ACT_QUERY: begin
                    if (r_lo < r_count) begin
                        r_fv  <= r_best;
                        r_pos <= PW'(r_lo);
                    end else begin
                        r_status <= slbq_pkg::ST_MISS;
                        r_pos    <= PW'(r_count);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status      = r_status;
    assign o_found_value = r_fv;
    assign o_position    = r_pos;

endmodule

### sv/sorted_lower_bound_query.sv
// channel   dir  handshake                    tdata                        tuser
// s_axis    in   s_axis_tvalid/s_axis_tready  value[31:0]                  action[1:0]
// m_axis    out  m_axis_tvalid/m_axis_tready  found_value[31:0],position   status[1:0]
//
// One item at a time; a search probe is a memory read plus a compare.
// Clear, an unused action and a dropped load go straight to the result. A query
// takes probes <= ceil(log2(count + 1)). A load searches as a query does, then
// moves each entry above the insert point up by one, a read then a write, and writes the key.
// Reset (synchronous, i_rst_n low) empties the store; no clearing pass is needed.
// A result waits in the output register; the next beat is taken meanwhile but
// its result holds until m_axis_tready frees that register.
module sorted_lower_bound_query #(
    parameter int DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // found_value[31:0], position[42:32], zeros[47:43]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    slbq_pkg::t_cmd cmd;
    slbq_pkg::t_sts sts;

    logic signed [slbq_pkg::DATA_W-1:0] found_value;
    logic [slbq_pkg::POS_W-1:0]         position;

    slbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    slbq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (s_axis_tuser),
        .i_value       (s_axis_tdata),
        .o_status      (m_axis_tuser),
        .o_found_value (found_value),
        .o_position    (position)
    );

    assign m_axis_tdata = {5'd0, position, found_value};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after a beat");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == slbq_pkg::ST_MISS) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("not-found result carries a value");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == slbq_pkg::ST_FULL) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("dropped load carries a value");

endmodule

### sim/tb_sorted_lower_bound_query.sv
`timescale 1ns / 100ps

module tb_sorted_lower_bound_query;

    localparam int STORE_DEPTH = 1024;
    localparam int LONG_HOLD   = 300;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] value;
        logic [3:0]  gap;     // idle cycles before the beat is offered
    } t_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [10:0] position;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // value[31:0]
    logic [1:0]  s_axis_tuser = '0;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // found_value[31:0], position[42:32], zeros[47:43]
    logic [1:0]  m_axis_tuser;        // status[1:0]

    sorted_lower_bound_query #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    t_beat   pending_beats[$];
    t_answer expected_answers[$];

    logic signed [31:0] sorted_copy [0:STORE_DEPTH-1];
    int unsigned        stored_count = 0;

    logic beat_taken = 1'b0;
    int   mismatches = 0;

    // sender-side idling
    int unsigned send_idle_pct = 0;
    int unsigned gap_left = 0;
    bit          gap_served = 1'b0;

    // receiver-side idling
    bit          calm_tail = 1'b0;
    int unsigned hold_asks = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned mode_left = 0;
    int unsigned ready_idle_pct = 0;

    // first index whose entry is >= key, or > key when past_equal is set
    function automatic int unsigned bound_index(input logic signed [31:0] key,
                                                input bit past_equal);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit          go_left;
        lo = 0;
        hi = stored_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            go_left = past_equal ? (sorted_copy[mid] > key) : (sorted_copy[mid] >= key);
            if (go_left)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic t_answer predict_answer(input logic [1:0] action,
                                               input logic signed [31:0] value);
        t_answer     ans;
        int unsigned at;
        int unsigned i;
        ans = '0;
        case (action)
            slbq_pkg::ACT_CLEAR: begin
                stored_count = 0;
            end
            slbq_pkg::ACT_LOAD: begin
                if (stored_count >= STORE_DEPTH) begin
                    ans.status   = slbq_pkg::ST_FULL;
                    ans.position = 11'(stored_count);
                end else begin
                    // equal values stay ahead of the new one
                    at = bound_index(value, 1'b1);
                    for (i = stored_count; i > at; i--)
                        sorted_copy[i] = sorted_copy[i - 1];
                    sorted_copy[at] = value;
                    stored_count++;
                    ans.status      = slbq_pkg::ST_OK;
                    ans.found_value = value;
                    ans.position    = 11'(at);
                end
            end
            slbq_pkg::ACT_QUERY: begin
                at = bound_index(value, 1'b0);
                if (at >= stored_count) begin
                    ans.status   = slbq_pkg::ST_MISS;
                    ans.position = 11'(stored_count);
                end else begin
                    ans.status      = slbq_pkg::ST_OK;
                    ans.found_value = sorted_copy[at];
                    ans.position    = 11'(at);
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // input side: predict every accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beat_taken   <= 1'b0;
            stored_count = 0;
        end else begin
            beat_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                expected_answers = {expected_answers,
                                    predict_answer(s_axis_tuser, s_axis_tdata)};
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_beat head;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !beat_taken) begin
            // hold the beat until it is taken
        end else if (gap_left != 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
            head = pending_beats[0];
            if (head.gap != 0 && !gap_served) begin
                gap_left      = head.gap - 1;
                gap_served    = 1'b1;
                s_axis_tvalid <= 1'b0;
            end else begin
                head          = pending_beats.pop_front();
                gap_served    = 1'b0;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= head.value;
                s_axis_tuser  <= head.action;
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: long hold-off on request, otherwise stall bursts in changing density
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_asks) begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (mode_left == 0) begin
                mode_left = $urandom_range(40, 400);
                case ($urandom_range(0, 2))
                    0:       ready_idle_pct = 0;
                    1:       ready_idle_pct = 10;
                    default: ready_idle_pct = 35;
                endcase
            end else begin
                mode_left--;
            end
            if (!calm_tail && $urandom_range(0, 99) < ready_idle_pct)
                stall_left = $urandom_range(1, 9);
        end
    end

    // output side: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result status %0d value %0d position %0d",
                         $time, m_axis_tuser, $signed(m_axis_tdata[31:0]),
                         m_axis_tdata[42:32]);
                mismatches++;
            end else begin
                want = expected_answers.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[31:0] !== want.found_value) begin
                    $display("%0t: found_value expected %0d actual %0d", $time,
                             $signed(want.found_value), $signed(m_axis_tdata[31:0]));
                    mismatches++;
                end
                if (m_axis_tdata[42:32] !== want.position) begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, m_axis_tdata[42:32]);
                    mismatches++;
                end
            end
        end
    end

    task automatic queue_beat(input logic [1:0] action, input logic [31:0] value);
        t_beat b;
        b.action = action;
        b.value  = value;
        b.gap    = '0;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            b.gap = 4'($urandom_range(1, 9));
        pending_beats = {pending_beats, b};
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return 32'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_quiet();
        do
            @(negedge i_clk);
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_answers.size() != 0);
    endtask

    // usually a clear, then loads and queries in random order, with a little noise;
    // returns the number of beats queued, not counting unused-action beats
    task automatic queue_data_set(inout logic [31:0] set_vals[$], output int queued);
        int          n_loads;
        int          n_queries;
        int unsigned pick;
        logic [31:0] key;
        queued = 0;
        if (set_vals.size() > 40 || $urandom_range(0, 7) != 0) begin
            queue_beat(slbq_pkg::ACT_CLEAR, $urandom);
            set_vals.delete();
            queued++;
        end
        n_loads   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        n_queries = $urandom_range(1, 10);
        while (n_loads + n_queries > 0) begin
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                queue_beat(ACT_UNUSED, $urandom);
            end else if (pick == 1) begin
                queue_beat(slbq_pkg::ACT_CLEAR, $urandom);
                set_vals.delete();
                queued++;
            end else if (n_loads > 0 && (n_queries == 0 || pick < 24)) begin
                key = pick_value();
                queue_beat(slbq_pkg::ACT_LOAD, key);
                set_vals = {set_vals, key};
                n_loads--;
                queued++;
            end else if (n_queries > 0) begin
                if (set_vals.size() != 0 && $urandom_range(0, 1) == 0)
                    key = set_vals[$urandom_range(0, set_vals.size() - 1)]
                          + 32'($urandom_range(0, 2)) - 32'd1;
                else
                    key = pick_value();
                queue_beat(slbq_pkg::ACT_QUERY, key);
                n_queries--;
                queued++;
            end
        end
    endtask

    initial begin
        logic [31:0] set_vals[$];
        logic [31:0] fill_val;
        int          sent;
        int          queued;
        int          k;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, duplicates, misses, unused action, clear
        send_idle_pct = 20;
        queue_beat(slbq_pkg::ACT_QUERY, 32'd0);
        queue_beat(slbq_pkg::ACT_CLEAR, 32'hFFFF_FFFF);
        queue_beat(slbq_pkg::ACT_LOAD, 32'd0);
        queue_beat(slbq_pkg::ACT_LOAD, VAL_MAX);
        queue_beat(slbq_pkg::ACT_LOAD, VAL_MIN);
        queue_beat(slbq_pkg::ACT_LOAD, 32'd0);
        queue_beat(slbq_pkg::ACT_LOAD, 32'hFFFF_FFFF);
        queue_beat(slbq_pkg::ACT_QUERY, VAL_MIN);
        queue_beat(slbq_pkg::ACT_QUERY, VAL_MAX);
        queue_beat(slbq_pkg::ACT_QUERY, 32'd1);
        queue_beat(slbq_pkg::ACT_QUERY, 32'd0);
        queue_beat(slbq_pkg::ACT_QUERY, VAL_MIN + 32'd1);
        queue_beat(ACT_UNUSED, 32'hFFFF_FFFF);
        queue_beat(ACT_UNUSED, 32'd0);
        queue_beat(slbq_pkg::ACT_CLEAR, 32'd0);
        queue_beat(slbq_pkg::ACT_QUERY, VAL_MIN);
        queue_beat(slbq_pkg::ACT_LOAD, 32'd5);
        queue_beat(slbq_pkg::ACT_QUERY, 32'd6);
        queue_beat(slbq_pkg::ACT_LOAD, 32'd5);
        queue_beat(slbq_pkg::ACT_QUERY, 32'd5);
        queue_beat(slbq_pkg::ACT_QUERY, 32'd4);
        queue_beat(slbq_pkg::ACT_CLEAR, 32'd0);
        wait_quiet();

        // random data sets; the receiver holds off early so the block backs up
        hold_asks++;
        sent = 0;
        while (sent < 850) begin
            case ($urandom_range(0, 2))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 10;
                default: send_idle_pct = 30;
            endcase
            queue_data_set(set_vals, queued);
            sent += queued;
        end
        wait_quiet();

        // fill the store in ascending order, then overflow it
        send_idle_pct = 10;
        queue_beat(slbq_pkg::ACT_CLEAR, 32'd0);
        fill_val = -32'sd5000;
        for (k = 0; k < STORE_DEPTH - 1; k++) begin
            queue_beat(slbq_pkg::ACT_LOAD, fill_val);
            fill_val += 32'($urandom_range(0, 3));
        end
        // insert at the front: moves every entry
        queue_beat(slbq_pkg::ACT_LOAD, VAL_MIN);
        queue_beat(slbq_pkg::ACT_LOAD, 32'd7);
        queue_beat(slbq_pkg::ACT_LOAD, VAL_MAX);
        queue_beat(ACT_UNUSED, 32'd7);
        queue_beat(slbq_pkg::ACT_QUERY, VAL_MIN);
        queue_beat(slbq_pkg::ACT_QUERY, VAL_MAX);
        queue_beat(slbq_pkg::ACT_QUERY, fill_val);
        for (k = 0; k < 20; k++)
            queue_beat(slbq_pkg::ACT_QUERY, 32'($urandom_range(0, 3200)) - 32'd5100);
        queue_beat(slbq_pkg::ACT_CLEAR, 32'd0);
        wait_quiet();

        // tail with no idling on either side
        calm_tail     = 1'b1;
        send_idle_pct = 0;
        set_vals.delete();
        sent = 0;
        while (sent < 100) begin
            queue_data_set(set_vals, queued);
            sent += queued;
        end
        wait_quiet();

        repeat (2 * STORE_DEPTH + 64) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
